// File: rtl/dnfp_pkg.sv
// ----------------------------------------------------------------------------
// dnfp_pkg
// Shared sizes, payload types, command/status structs and arithmetic helpers
// for the dense network forward pass.
// ----------------------------------------------------------------------------
package dnfp_pkg;

    localparam int INPUT_DIM     = 8;
    localparam int HIDDEN_WIDTH  = 8;
    localparam int HIDDEN_LAYERS = 2;
    localparam int OUTPUT_DIM    = 4;

    localparam int WEIGHT_COUNT = INPUT_DIM * HIDDEN_WIDTH
                                + (HIDDEN_LAYERS - 1) * HIDDEN_WIDTH * HIDDEN_WIDTH
                                + HIDDEN_WIDTH * OUTPUT_DIM;
    localparam int VEC_MAX = (INPUT_DIM > HIDDEN_WIDTH)
                           ? ((INPUT_DIM > OUTPUT_DIM) ? INPUT_DIM : OUTPUT_DIM)
                           : ((HIDDEN_WIDTH > OUTPUT_DIM) ? HIDDEN_WIDTH : OUTPUT_DIM);
    localparam int NUM_LAYERS = HIDDEN_LAYERS + 1;

    localparam int WA_W  = $clog2(WEIGHT_COUNT);
    localparam int VI_W  = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
    localparam int VC_W  = $clog2(VEC_MAX + 1);
    localparam int LY_W  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int FC_W  = $clog2(INPUT_DIM + 1);
    localparam int ACC_W = 32 + VI_W + 1;

    typedef struct packed {
        logic              mode;
        logic [7:0]        weight_address;
        logic signed [15:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         output_index;
        logic signed [15:0] output_value;
        logic               last_output;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic             clr;      // clear accumulator
        logic             mac;      // issue multiply-accumulate
        logic [VI_W-1:0]  row;
        logic [WA_W-1:0]  waddr;
        logic             src_sel;  // 0: buffer A, 1: buffer B
        logic             fin;      // finish neuron
        logic [VI_W-1:0]  col;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic             busy;     // pipeline still holds work
    } t_dp_sts;

    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-13:0] q;
        t = acc + ACC_W'(2048);
        q = t[ACC_W-1:12];
        if (q > 32767)       round_sat = 16'sh7fff;
        else if (q < -32768) round_sat = 16'sh8000;
        else                 round_sat = q[15:0];
    endfunction

    function automatic logic signed [15:0] sigmoid_q12(input logic signed [15:0] x);
        logic [16:0] a;
        logic [16:0] y;
        a = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        if (a >= 17'd20480)     y = 17'd4096;
        else if (a >= 17'd9728) y = (a >> 5) + 17'd3456;
        else if (a >= 17'd4096) y = (a >> 3) + 17'd2560;
        else                    y = (a >> 2) + 17'd2048;
        if (x[15]) y = 17'd4096 - y;
        sigmoid_q12 = y[15:0];
    endfunction

endpackage

// File: rtl/dense_network_forward_pass.sv
// ----------------------------------------------------------------------------
// dense_network_forward_pass
// Top level: MLP inference engine with Q4.12 arithmetic and sigmoid or
// identity activation.
// ----------------------------------------------------------------------------
// Weight-load and feature requests are taken while the sequencer is idle;
// the last feature of a vector starts the forward pass, during which input
// stall stays high. One shared MAC does one multiply-accumulate a cycle while
// the sequencer is in its MAC state, and each layer waits for the pipeline to
// drain before the next starts. Outputs are then sent one by one and held
// while output stall is high. Results sit in an output register.
module dense_network_forward_pass import dnfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic               r_act_kind;
    logic               wr_en, feat_en;
    logic [WA_W-1:0]    wr_addr;
    logic [VI_W-1:0]    feat_idx;
    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic signed [15:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_kind <= 1'b0;
        end else if (i_cfg_we) begin
            r_act_kind <= i_cfg_wdata;
        end
    end

    dnfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_feat_en   (feat_en),
        .o_feat_idx  (feat_idx),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .i_result    (result),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    dnfp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act_kind (r_act_kind),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (i_in_data.data_value),
        .i_feat_en  (feat_en),
        .i_feat_idx (feat_idx),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (result)
    );

endmodule

// File: rtl/dnfp_datapath.sv
// ----------------------------------------------------------------------------
// dnfp_datapath
// Weight memory, ping-pong activation buffers and one shared MAC with
// rounding, saturation and activation.
// ----------------------------------------------------------------------------
module dnfp_datapath import dnfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_act_kind,
    input  logic               i_wr_en,
    input  logic [WA_W-1:0]    i_wr_addr,
    input  logic signed [15:0] i_wr_data,
    input  logic               i_feat_en,
    input  logic [VI_W-1:0]    i_feat_idx,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic signed [15:0] o_result
);

    logic signed [15:0] r_wmem [WEIGHT_COUNT];
    logic signed [15:0] r_buf_a [VEC_MAX];
    logic signed [15:0] r_buf_b [VEC_MAX];

    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic               r_s1_mac, r_s1_clr, r_s1_fin, r_s1_dst;
    logic [VI_W-1:0]    r_s1_col;
    logic signed [31:0] r_prod;
    logic               r_s2_mac, r_s2_clr, r_s2_fin, r_s2_dst;
    logic [VI_W-1:0]    r_s2_col;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_s3_fin, r_s3_dst;
    logic [VI_W-1:0]    r_s3_col;
    logic signed [15:0] r_result;

    logic signed [ACC_W-1:0] n_acc;
    logic signed [15:0]      n_rs;
    logic signed [15:0]      n_act;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wmem[i_wr_addr] <= i_wr_data;
        end
        r_w <= r_wmem[i_cmd.waddr];
    end

    always_ff @(posedge i_clk) begin
        r_x    <= i_cmd.src_sel ? r_buf_b[i_cmd.row] : r_buf_a[i_cmd.row];
        r_prod <= r_x * r_w;
        r_acc  <= n_acc;
        if (i_feat_en) begin
            r_buf_a[i_feat_idx] <= i_wr_data;
        end
        if (r_s3_fin) begin
            if (r_s3_dst) r_buf_b[r_s3_col] <= n_act;
            else          r_buf_a[r_s3_col] <= n_act;
            r_result <= n_act;
        end
        r_s1_col <= i_cmd.col;
        r_s1_dst <= ~i_cmd.src_sel;
        r_s2_col <= r_s1_col;
        r_s2_dst <= r_s1_dst;
        r_s3_col <= r_s2_col;
        r_s3_dst <= r_s2_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_mac <= 1'b0;
            r_s1_clr <= 1'b0;
            r_s1_fin <= 1'b0;
            r_s2_mac <= 1'b0;
            r_s2_clr <= 1'b0;
            r_s2_fin <= 1'b0;
            r_s3_fin <= 1'b0;
        end else begin
            r_s1_mac <= i_cmd.mac;
            r_s1_clr <= i_cmd.clr;
            r_s1_fin <= i_cmd.fin;
            r_s2_mac <= r_s1_mac;
            r_s2_clr <= r_s1_clr;
            r_s2_fin <= r_s1_fin;
            r_s3_fin <= r_s2_fin;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_s2_mac) begin
            n_acc = (r_s2_clr ? '0 : r_acc) + ACC_W'(r_prod);
        end
        n_rs  = round_sat(r_acc);
        n_act = i_act_kind ? n_rs : sigmoid_q12(n_rs);
    end

    assign o_sts.busy = r_s1_mac | r_s2_mac | r_s1_fin | r_s2_fin | r_s3_fin;
    assign o_result   = r_result;

endmodule

// File: rtl/dnfp_ctrl.sv
// ----------------------------------------------------------------------------
// dnfp_ctrl
// Sequencer: counts features, walks layers, columns and rows, issues MAC
// commands and hands results to the output register.
// ----------------------------------------------------------------------------
module dnfp_ctrl import dnfp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  t_in_item        i_in_data,
    output logic            o_in_stall,
    output logic            o_wr_en,
    output logic [WA_W-1:0] o_wr_addr,
    output logic            o_feat_en,
    output logic [VI_W-1:0] o_feat_idx,
    output t_dp_cmd         o_cmd,
    input  t_dp_sts         i_sts,
    input  logic signed [15:0] i_result,
    output logic            o_out_valid,
    output t_out_item       o_out_data,
    input  logic            i_out_stall
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [FC_W-1:0]   r_fcnt;
    logic [LY_W-1:0]   r_layer;
    logic [VC_W-1:0]   r_col;
    logic [VC_W-1:0]   r_row;
    logic [WA_W:0]     r_base;
    logic              r_src;
    logic              r_ovalid;
    t_out_item         r_odata;

    logic              accept;
    logic              out_take;
    logic [VC_W-1:0]   rows, cols;
    logic              last_layer;
    logic [WA_W+VC_W+VC_W:0] waddr_full;

    always_comb begin
        last_layer = (r_layer == LY_W'(NUM_LAYERS - 1));
        rows = (r_layer == '0) ? VC_W'(INPUT_DIM) : VC_W'(HIDDEN_WIDTH);
        cols = last_layer ? VC_W'(OUTPUT_DIM) : VC_W'(HIDDEN_WIDTH);
        waddr_full = (WA_W+VC_W+VC_W+1)'(r_base)
                   + (WA_W+VC_W+VC_W+1)'(r_row) * (WA_W+VC_W+VC_W+1)'(cols)
                   + (WA_W+VC_W+VC_W+1)'(r_col);
    end

    assign accept   = i_in_valid & ~o_in_stall;
    assign out_take = r_ovalid & ~i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign o_wr_en    = accept & ~i_in_data.mode
                      & (i_in_data.weight_address < 8'(WEIGHT_COUNT));
    assign o_wr_addr  = i_in_data.weight_address[WA_W-1:0];
    assign o_feat_en  = accept & i_in_data.mode;
    assign o_feat_idx = r_fcnt[VI_W-1:0];

    always_comb begin
        o_cmd         = '0;
        o_cmd.row     = r_row[VI_W-1:0];
        o_cmd.col     = r_col[VI_W-1:0];
        o_cmd.src_sel = r_src;
        o_cmd.waddr   = waddr_full[WA_W-1:0];
        o_cmd.mac     = (r_state == ST_MAC);
        o_cmd.clr     = (r_state == ST_MAC) && (r_row == '0);
        o_cmd.fin     = (r_state == ST_FIN);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_feat_en && (r_fcnt == FC_W'(INPUT_DIM - 1))) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_row == rows - VC_W'(1)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (r_col != cols - VC_W'(1))          n_state = ST_MAC;
                else                                    n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_sts.busy) n_state = last_layer ? ST_EMIT : ST_MAC;
            end
            ST_EMIT: begin
                if (!r_ovalid || out_take) begin
                    if (r_col == cols - VC_W'(1)) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fcnt   <= '0;
            r_layer  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_base   <= '0;
            r_src    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_take) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_feat_en) begin
                        r_fcnt <= (r_fcnt == FC_W'(INPUT_DIM - 1)) ? '0 : r_fcnt + FC_W'(1);
                    end
                    r_layer <= '0;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_base  <= '0;
                    r_src   <= 1'b0;
                end
                ST_MAC: begin
                    r_row <= r_row + VC_W'(1);
                end
                ST_FIN: begin
                    r_row <= '0;
                    if (r_col != cols - VC_W'(1)) r_col <= r_col + VC_W'(1);
                end
                ST_WAIT: begin
                    if (!i_sts.busy) begin
                        r_col <= '0;
                        if (!last_layer) begin
                            r_base  <= r_base + (WA_W+1)'(rows) * (WA_W+1)'(cols);
                            r_layer <= r_layer + LY_W'(1);
                            r_src   <= ~r_src;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid || out_take) begin
                        r_ovalid <= 1'b1;
                        r_col    <= r_col + VC_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // capture each finished neuron value once its fin command has passed through r_fin_pipe
    logic [2:0]        r_fin_pipe;
    logic [VI_W-1:0]   r_fcol [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_pipe <= '0;
        end else begin
            r_fin_pipe <= {r_fin_pipe[1:0], o_cmd.fin};
        end
        r_fcol[0] <= r_col[VI_W-1:0];
        r_fcol[1] <= r_fcol[0];
        r_fcol[2] <= r_fcol[1];
    end
    logic signed [15:0] r_cap [VEC_MAX];
    logic               r_cap_v;
    logic [VI_W-1:0]    r_cap_col;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap_v <= 1'b0;
        else          r_cap_v <= r_fin_pipe[2];
        r_cap_col <= r_fcol[2];
        if (r_cap_v) r_cap[r_cap_col] <= i_result;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && (!r_ovalid || out_take)) begin
            r_odata.output_index <= 2'(r_col);
            r_odata.output_value <= r_cap[r_col[VI_W-1:0]];
            r_odata.last_output  <= (r_col == cols - VC_W'(1));
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for dense_network_forward_pass. The weight memory is loaded in
// full, then directed and random feature vectors run under both activations.
// The driver and the monitor add random idle and stall bursts. Every result
// is checked against a local Q4.12 forward-pass predictor.
// ----------------------------------------------------------------------------
module tb;
    import dnfp_pkg::*;

    localparam logic MODE_WEIGHT  = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;
    localparam logic ACT_SIGMOID  = 1'b0;
    localparam logic ACT_LINEAR   = 1'b1;
    localparam int   DRAIN_CYCLES = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_wdata;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    dense_network_forward_pass DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    t_in_item  request_queue[$];
    t_out_item expected_outputs[$];

    logic signed [15:0] weights [WEIGHT_COUNT];
    logic signed [15:0] features [INPUT_DIM];
    int   feature_cnt;
    logic act_kind;
    bit   quiet;
    int   errors;
    int   results_seen;
    int   vectors_sigmoid;
    int   vectors_linear;
    int   weight_loads;
    int   send_gap;
    int   recv_gap;
    int   hold_cnt;
    bit   hold_done;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic signed [15:0] round_saturate(input longint acc);
        longint q;
        q = (acc + 2048) >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    function automatic logic signed [15:0] squash(input logic signed [15:0] x);
        int a;
        int y;
        a = (x < 0) ? -int'(x) : int'(x);
        if (a >= 20480)     y = 4096;
        else if (a >= 9728) y = (a >> 5) + 3456;
        else if (a >= 4096) y = (a >> 3) + 2560;
        else                y = (a >> 2) + 2048;
        if (x < 0) y = 4096 - y;
        return 16'(y);
    endfunction

    task automatic compute_layer(input logic signed [15:0] src[VEC_MAX],
                                 output logic signed [15:0] dst[VEC_MAX],
                                 input int rows, input int cols, input int base);
        longint acc;
        logic signed [15:0] v;
        for (int c = 0; c < VEC_MAX; c++) dst[c] = '0;
        for (int c = 0; c < cols; c++) begin
            acc = 0;
            for (int r = 0; r < rows; r++)
                acc += longint'(src[r]) * longint'(weights[base + r * cols + c]);
            v = round_saturate(acc);
            dst[c] = (act_kind == ACT_LINEAR) ? v : squash(v);
        end
    endtask

    task automatic predict_request(input t_in_item req);
        logic signed [15:0] a[VEC_MAX];
        logic signed [15:0] b[VEC_MAX];
        int base;
        t_out_item res;
        if (req.mode == MODE_WEIGHT) begin
            if (req.weight_address < WEIGHT_COUNT) weights[req.weight_address] = req.data_value;
            weight_loads++;
            return;
        end
        features[feature_cnt] = req.data_value;
        feature_cnt++;
        if (feature_cnt < INPUT_DIM) return;
        feature_cnt = 0;
        for (int k = 0; k < VEC_MAX; k++) a[k] = (k < INPUT_DIM) ? features[k] : '0;
        compute_layer(a, b, INPUT_DIM, HIDDEN_WIDTH, 0);
        base = INPUT_DIM * HIDDEN_WIDTH;
        for (int l = 1; l < HIDDEN_LAYERS; l++) begin
            a = b;
            compute_layer(a, b, HIDDEN_WIDTH, HIDDEN_WIDTH, base);
            base += HIDDEN_WIDTH * HIDDEN_WIDTH;
        end
        a = b;
        compute_layer(a, b, HIDDEN_WIDTH, OUTPUT_DIM, base);
        for (int k = 0; k < OUTPUT_DIM; k++) begin
            res.output_index = 2'(k);
            res.output_value = b[k];
            res.last_output  = (k == OUTPUT_DIM - 1);
            expected_outputs.push_back(res);
        end
        if (act_kind == ACT_LINEAR) vectors_linear++;
        else vectors_sigmoid++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_request(i_in_data);
                void'(request_queue.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
                // hold
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (request_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= $urandom_range(0, 13);
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= request_queue[0];
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap    <= 0;
            hold_cnt    <= 0;
            hold_done   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_outputs.size() == 0) begin
                    $error("unexpected result: index %0d value %0d last %0d",
                           o_out_data.output_index, o_out_data.output_value,
                           o_out_data.last_output);
                    errors++;
                end else begin
                    exp_item = expected_outputs.pop_front();
                    if (o_out_data.output_index !== exp_item.output_index) begin
                        $error("output_index: expected %0d, actual %0d",
                               exp_item.output_index, o_out_data.output_index);
                        errors++;
                    end
                    if (o_out_data.output_value !== exp_item.output_value) begin
                        $error("output_value: expected %0d, actual %0d",
                               exp_item.output_value, o_out_data.output_value);
                        errors++;
                    end
                    if (o_out_data.last_output !== exp_item.last_output) begin
                        $error("last_output: expected %0d, actual %0d",
                               exp_item.last_output, o_out_data.last_output);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                i_out_stall <= 1'b1;
                hold_cnt    <= hold_cnt - 1;
            end else if (!hold_done && results_seen >= 6) begin
                i_out_stall <= 1'b1;
                hold_cnt    <= 900;
                hold_done   <= 1'b1;
            end else if (recv_gap > 0) begin
                i_out_stall <= 1'b1;
                recv_gap    <= recv_gap - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                recv_gap    <= $urandom_range(0, 13);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic add_request(input logic mode, input int addr, input logic signed [15:0] val);
        t_in_item req;
        req.mode           = mode;
        req.weight_address = 8'(addr);
        req.data_value     = val;
        request_queue.push_back(req);
    endtask

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed(12'($urandom)));
        endcase
    endfunction

    task automatic add_vector(input logic signed [15:0] val, input bit rand_fill);
        for (int k = 0; k < INPUT_DIM; k++)
            add_request(MODE_FEATURE, 0, rand_fill ? random_value() : val);
    endtask

    task automatic add_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 7)
                add_request(MODE_FEATURE, 0, random_value());
            else
                add_request(MODE_WEIGHT, $urandom_range(0, 255), random_value());
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (request_queue.size() != 0 || i_in_valid || expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_activation(input logic kind);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kind;
        act_kind = kind;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        act_kind    = ACT_SIGMOID;
        feature_cnt = 0;
        quiet       = 1'b0;
        errors      = 0;
        results_seen = 0;
        vectors_sigmoid = 0;
        vectors_linear  = 0;
        weight_loads    = 0;
        for (int k = 0; k < WEIGHT_COUNT; k++) weights[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_activation(ACT_SIGMOID);

        // fill every weight before any vector completes
        for (int k = 0; k < WEIGHT_COUNT; k++)
            add_request(MODE_WEIGHT, k, (k == 3) ? 16'sh7fff : (k == 70) ? 16'sh8000 :
                        16'($signed(11'($urandom))));
        add_vector(16'sh7fff, 0);
        add_vector(16'sh8000, 0);
        add_vector(16'sh0000, 0);
        // weight load and out-of-range loads inside a partial vector
        add_request(MODE_FEATURE, 0, 16'sh1000);
        add_request(MODE_WEIGHT, WEIGHT_COUNT, 16'sh7fff);
        add_request(MODE_WEIGHT, 255, 16'sh8000);
        add_request(MODE_WEIGHT, 12, 16'shf000);
        for (int k = 1; k < INPUT_DIM; k++) add_request(MODE_FEATURE, 0, 16'shf000);
        wait_idle();

        write_activation(ACT_LINEAR);
        add_vector(0, 1);
        add_random(12);
        wait_idle();

        write_activation(ACT_SIGMOID);
        add_random(8);
        wait_idle();

        write_activation(ACT_LINEAR);
        quiet = 1'b1;
        add_random(4);
        wait_idle();
        // complete any partial vector
        if (feature_cnt != 0) begin
            for (int k = feature_cnt; k < INPUT_DIM; k++)
                add_request(MODE_FEATURE, 0, random_value());
        end
        wait_idle();

        $display("Vectors: %0d sigmoid, %0d linear; weight loads %0d; results %0d",
                 vectors_sigmoid, vectors_linear, weight_loads, results_seen);
        $display("Covered saturation, both activations, stray loads and long output hold");
        if (errors == 0 && expected_outputs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end
endmodule
